[rtl/smts_pkg.sv]
// Shared types and constants for the sparse matrix term store.
package smts_pkg;

  localparam int unsigned ValueBits = 32;
  localparam int unsigned SizeBits  = 13;
  localparam int unsigned PaddrBits = 3;
  localparam int unsigned PdataBits = 32;

  typedef enum logic [1:0] {
    CmdSet       = 2'd0,
    CmdGet       = 2'd1,
    CmdTranspose = 2'd2,
    CmdNone      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusFull     = 2'd1,
    StatusRange    = 2'd2,
    StatusReserved = 2'd3
  } status_e;

  typedef enum logic {
    RegRowCount    = 1'b0,
    RegColumnCount = 1'b1
  } reg_e;

  localparam logic [SizeBits-1:0] SizeReset = 13'd4096;

endpackage

[rtl/smts_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module smts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/sparse_matrix_term_store.sv]
// Top level of the sparse matrix term store: sequencer around the term RAM.
//
//  channel | direction | handshake                  | payload
//  in      | to block  | in_valid_i / in_stall_o    | cmd, row_index, col_index, term_value
//  out     | from block| out_valid_o / out_stall_i  | out_row .. status
//  config  | to block  | APB psel/penable/pwrite    | row_count, column_count
//
// One item is processed at a time. A set or get scans the sorted table term by term
// through the single RAM read port, reading in StScanRd and checking in StScanCk; an
// insert then moves each later term up, reading it in StShiftRd and writing it in
// StShiftWr. A transpose makes one scan of all n terms for each result. Reset empties
// the table at once through the term count. A stalled output holds the sequencer in its
// emit state; a new input beat is taken only when the sequencer is idle.
module sparse_matrix_term_store #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smts_pkg::PaddrBits-1:0]      paddr,
  input  logic [smts_pkg::PdataBits-1:0]      pwdata,
  output logic [smts_pkg::PdataBits-1:0]      prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          cmd_i,
  input  logic [COORD_BITS-1:0]               row_index_i,
  input  logic [COORD_BITS-1:0]               col_index_i,
  input  logic [smts_pkg::ValueBits-1:0]      term_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [COORD_BITS-1:0]               out_row_o,
  output logic [COORD_BITS-1:0]               out_col_o,
  output logic [smts_pkg::ValueBits-1:0]      out_value_o,
  output logic                                found_o,
  output logic                                item_valid_o,
  output logic                                last_o,
  output logic [1:0]                          status_o
);
  import smts_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = 2 * CB + ValueBits;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = 2 * CB;
  localparam int unsigned RW = (CB > SizeBits) ? CB + 1 : SizeBits + 1;

  typedef enum logic [2:0] {
    StIdle, StScanRd, StScanCk, StPlace, StShiftRd, StShiftWr, StInsert, StEmit
  } state_e;

  state_e state_q, state_d;
  cmd_e cmd_q, cmd_d;
  logic [CB-1:0] row_q, row_d, col_q, col_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, pos_q, pos_d, emitted_q, emitted_d;
  logic [KW-1:0] best_key_q, best_key_d, prev_key_q, prev_key_d;
  logic [ValueBits-1:0] best_val_q, best_val_d;
  logic have_best_q, have_best_d, have_prev_q, have_prev_d;
  logic [SizeBits-1:0] row_count_q, row_count_d, col_count_q, col_count_d;

  logic [CB-1:0] res_row_q, res_row_d, res_col_q, res_col_d;
  logic [ValueBits-1:0] res_val_q, res_val_d;
  logic res_found_q, res_found_d, res_valid_q, res_valid_d, res_last_q, res_last_d;
  status_e res_status_q, res_status_d;

  logic out_valid_q, out_valid_d;
  logic [CB-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic [ValueBits-1:0] out_val_q, out_val_d;
  logic out_found_q, out_found_d, out_item_q, out_item_d, out_last_q, out_last_d;
  logic [1:0] out_status_q, out_status_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [CB-1:0] e_row, e_col;
  logic [ValueBits-1:0] e_val;
  logic [KW-1:0] key_rm, e_key_rm, key_cm, e_key_cm;
  logic cfg_write, in_accept;

  smts_ram #(.Width(EW), .Depth(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign e_row    = rdata[EW-1 -: CB];
  assign e_col    = rdata[CB+ValueBits-1 -: CB];
  assign e_val    = rdata[ValueBits-1:0];
  assign key_rm   = {row_q, col_q};
  assign e_key_rm = {e_row, e_col};
  assign e_key_cm = {e_col, e_row};
  assign key_cm   = e_key_cm;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_e'(paddr[2]) == RegRowCount) ? PdataBits'(row_count_q)
                                                       : PdataBits'(col_count_q);

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign out_value_o  = out_val_q;
  assign found_o      = out_found_q;
  assign item_valid_o = out_item_q;
  assign last_o       = out_last_q;
  assign status_o     = out_status_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    row_d        = row_q;
    col_d        = col_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    emitted_d    = emitted_q;
    best_key_d   = best_key_q;
    best_val_d   = best_val_q;
    have_best_d  = have_best_q;
    prev_key_d   = prev_key_q;
    have_prev_d  = have_prev_q;
    row_count_d  = row_count_q;
    col_count_d  = col_count_q;
    res_row_d    = res_row_q;
    res_col_d    = res_col_q;
    res_val_d    = res_val_q;
    res_found_d  = res_found_q;
    res_valid_d  = res_valid_q;
    res_last_d   = res_last_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_val_d    = out_val_q;
    out_found_d  = out_found_q;
    out_item_d   = out_item_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    we           = 1'b0;
    waddr        = idx_q[AW-1:0];
    wdata        = {row_q, col_q, val_q};
    raddr        = idx_q[AW-1:0];

    if (cfg_write) begin
      if (reg_e'(paddr[2]) == RegRowCount) begin
        row_count_d = pwdata[SizeBits-1:0];
      end else begin
        col_count_d = pwdata[SizeBits-1:0];
      end
    end

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          cmd_d        = cmd_e'(cmd_i);
          row_d        = row_index_i;
          col_d        = col_index_i;
          val_d        = term_value_i;
          idx_d        = '0;
          emitted_d    = '0;
          have_best_d  = 1'b0;
          have_prev_d  = 1'b0;
          res_row_d    = row_index_i;
          res_col_d    = col_index_i;
          res_val_d    = '0;
          res_found_d  = 1'b0;
          res_valid_d  = 1'b0;
          res_last_d   = 1'b1;
          res_status_d = StatusOk;
          state_d      = StScanRd;
          case (cmd_e'(cmd_i))
            CmdSet: begin
              if (term_value_i[ValueBits-2:0] == '0) begin
                state_d = StEmit;
              end else if (!((RW'(row_index_i) < RW'(row_count_q)) &&
                             (RW'(col_index_i) < RW'(col_count_q)))) begin
                res_status_d = StatusRange;
                state_d      = StEmit;
              end else if (cnt_q == '0) begin
                pos_d   = '0;
                state_d = StPlace;
              end
            end
            CmdGet: begin
              if (!((RW'(row_index_i) < RW'(row_count_q)) &&
                    (RW'(col_index_i) < RW'(col_count_q)))) begin
                res_status_d = StatusRange;
                state_d      = StEmit;
              end else if (cnt_q == '0) begin
                pos_d   = '0;
                state_d = StPlace;
              end
            end
            CmdTranspose: begin
              res_row_d = '0;
              res_col_d = '0;
              if (cnt_q == '0) begin
                state_d = StEmit;
              end
            end
            default: begin
              res_row_d = '0;
              res_col_d = '0;
              state_d   = StEmit;
            end
          endcase
        end
      end

      StScanRd: begin
        state_d = StScanCk;
      end

      StScanCk: begin
        idx_d = idx_q + 1'b1;
        if (cmd_q == CmdTranspose) begin
          if ((!have_prev_q || key_cm > prev_key_q) &&
              (!have_best_q || key_cm < best_key_q)) begin
            have_best_d = 1'b1;
            best_key_d  = key_cm;
            best_val_d  = e_val;
          end
          state_d = StScanRd;
          if (idx_q + 1'b1 == cnt_q) begin
            state_d = StEmit;
            if ((!have_prev_q || key_cm > prev_key_q) &&
                (!have_best_q || key_cm < best_key_q)) begin
              res_row_d  = e_col;
              res_col_d  = e_row;
              res_val_d  = e_val;
              prev_key_d = key_cm;
            end else begin
              res_row_d  = best_key_q[KW-1 -: CB];
              res_col_d  = best_key_q[CB-1:0];
              res_val_d  = best_val_q;
              prev_key_d = best_key_q;
            end
            have_prev_d = 1'b1;
            res_valid_d = 1'b1;
            res_last_d  = (emitted_q + 1'b1 == cnt_q);
            emitted_d   = emitted_q + 1'b1;
          end
        end else if (e_key_rm == key_rm) begin
          if (cmd_q == CmdGet) begin
            res_val_d   = e_val;
            res_found_d = 1'b1;
          end else begin
            we = 1'b1;
          end
          state_d = StEmit;
        end else if (key_rm < e_key_rm) begin
          pos_d   = idx_q;
          state_d = StPlace;
        end else if (idx_q + 1'b1 == cnt_q) begin
          pos_d   = cnt_q;
          state_d = StPlace;
        end else begin
          state_d = StScanRd;
        end
      end

      StPlace: begin
        if (cmd_q != CmdSet) begin
          state_d = StEmit;
        end else if (cnt_q == CW'(CAPACITY)) begin
          res_status_d = StatusFull;
          state_d      = StEmit;
        end else begin
          idx_d   = cnt_q;
          state_d = (cnt_q == pos_q) ? StInsert : StShiftRd;
        end
      end

      StShiftRd: begin
        raddr   = AW'(idx_q - 1'b1);
        state_d = StShiftWr;
      end

      StShiftWr: begin
        we      = 1'b1;
        wdata   = rdata;
        idx_d   = idx_q - 1'b1;
        state_d = (idx_q - 1'b1 == pos_q) ? StInsert : StShiftRd;
      end

      StInsert: begin
        we      = 1'b1;
        waddr   = pos_q[AW-1:0];
        cnt_d   = cnt_q + 1'b1;
        state_d = StEmit;
      end

      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_row_d    = res_row_q;
          out_col_d    = res_col_q;
          out_val_d    = res_val_q;
          out_found_d  = res_found_q;
          out_item_d   = res_valid_q;
          out_last_d   = res_last_q;
          out_status_d = res_status_q;
          if (cmd_q == CmdTranspose && !res_last_q) begin
            idx_d       = '0;
            have_best_d = 1'b0;
            state_d     = StScanRd;
          end else begin
            state_d = StIdle;
          end
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cmd_q        <= CmdNone;
      row_q        <= '0;
      col_q        <= '0;
      val_q        <= '0;
      cnt_q        <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      emitted_q    <= '0;
      best_key_q   <= '0;
      best_val_q   <= '0;
      have_best_q  <= 1'b0;
      prev_key_q   <= '0;
      have_prev_q  <= 1'b0;
      row_count_q  <= SizeReset;
      col_count_q  <= SizeReset;
      res_row_q    <= '0;
      res_col_q    <= '0;
      res_val_q    <= '0;
      res_found_q  <= 1'b0;
      res_valid_q  <= 1'b0;
      res_last_q   <= 1'b0;
      res_status_q <= StatusOk;
      out_valid_q  <= 1'b0;
      out_row_q    <= '0;
      out_col_q    <= '0;
      out_val_q    <= '0;
      out_found_q  <= 1'b0;
      out_item_q   <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      row_q        <= row_d;
      col_q        <= col_d;
      val_q        <= val_d;
      cnt_q        <= cnt_d;
      idx_q        <= idx_d;
      pos_q        <= pos_d;
      emitted_q    <= emitted_d;
      best_key_q   <= best_key_d;
      best_val_q   <= best_val_d;
      have_best_q  <= have_best_d;
      prev_key_q   <= prev_key_d;
      have_prev_q  <= have_prev_d;
      row_count_q  <= row_count_d;
      col_count_q  <= col_count_d;
      res_row_q    <= res_row_d;
      res_col_q    <= res_col_d;
      res_val_q    <= res_val_d;
      res_found_q  <= res_found_d;
      res_valid_q  <= res_valid_d;
      res_last_q   <= res_last_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      out_row_q    <= out_row_d;
      out_col_q    <= out_col_d;
      out_val_q    <= out_val_d;
      out_found_q  <= out_found_d;
      out_item_q   <= out_item_d;
      out_last_q   <= out_last_d;
      out_status_q <= out_status_d;
    end
  end

endmodule

[bench/sparse_matrix_term_store_checker.sv]
// Checker for the sparse matrix term store: predicts every output beat and compares it.
module sparse_matrix_term_store_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [smts_pkg::PaddrBits-1:0]    paddr,
  input  logic [smts_pkg::PdataBits-1:0]    pwdata,
  input  logic                              pready,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic [1:0]                        cmd_i,
  input  logic [11:0]                       row_index_i,
  input  logic [11:0]                       col_index_i,
  input  logic [31:0]                       term_value_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [11:0]                       out_row_o,
  input  logic [11:0]                       out_col_o,
  input  logic [31:0]                       out_value_o,
  input  logic                              found_o,
  input  logic                              item_valid_o,
  input  logic                              last_o,
  input  logic [1:0]                        status_o,
  output int                                fail_count,
  output int                                pending_count
);
  import smts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity = 64;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [31:0] value;
    logic        found;
    logic        item_valid;
    logic        last;
    status_e     status;
  } beat_t;

  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [31:0] value;
  } term_t;

  term_t       terms[Capacity];
  int          term_num;
  logic [12:0] rows_in_use, cols_in_use;
  beat_t       expected_beats[$];

  function automatic beat_t make_beat(logic [11:0] r, logic [11:0] c, logic [31:0] v,
                                      logic f, logic iv, logic l, status_e s);
    beat_t b;
    b.row = r; b.col = c; b.value = v; b.found = f;
    b.item_valid = iv; b.last = l; b.status = s;
    return b;
  endfunction

  task automatic predict_command(cmd_e cmd, logic [11:0] r, logic [11:0] c, logic [31:0] v);
    int pos;
    int cnt;
    logic [23:0] key;
    logic [23:0] tkey;
    term_t sorted[$];
    term_t t;
    int j;
    key = {r, c};
    case (cmd)
      CmdSet: begin
        if (v[30:0] == 0) begin
          expected_beats.push_back(make_beat(r, c, 0, 0, 0, 1, StatusOk));
        end else if ({1'b0, r} >= rows_in_use || {1'b0, c} >= cols_in_use) begin
          expected_beats.push_back(make_beat(r, c, 0, 0, 0, 1, StatusRange));
        end else begin
          pos = 0;
          while (pos < term_num && {terms[pos].row, terms[pos].col} < key) pos++;
          if (pos < term_num && {terms[pos].row, terms[pos].col} == key) begin
            terms[pos].value = v;
            expected_beats.push_back(make_beat(r, c, 0, 0, 0, 1, StatusOk));
          end else if (term_num >= Capacity) begin
            expected_beats.push_back(make_beat(r, c, 0, 0, 0, 1, StatusFull));
          end else begin
            for (j = term_num; j > pos; j--) terms[j] = terms[j-1];
            terms[pos] = '{r, c, v};
            term_num++;
            expected_beats.push_back(make_beat(r, c, 0, 0, 0, 1, StatusOk));
          end
        end
      end
      CmdGet: begin
        if ({1'b0, r} >= rows_in_use || {1'b0, c} >= cols_in_use) begin
          expected_beats.push_back(make_beat(r, c, 0, 0, 0, 1, StatusRange));
        end else begin
          pos = -1;
          for (j = 0; j < term_num; j++)
            if ({terms[j].row, terms[j].col} == key) pos = j;
          if (pos >= 0)
            expected_beats.push_back(make_beat(r, c, terms[pos].value, 1, 0, 1, StatusOk));
          else
            expected_beats.push_back(make_beat(r, c, 0, 0, 0, 1, StatusOk));
        end
      end
      CmdTranspose: begin
        if (term_num == 0) begin
          expected_beats.push_back(make_beat(0, 0, 0, 0, 0, 1, StatusOk));
        end else begin
          for (j = 0; j < term_num; j++) begin
            t = terms[j];
            tkey = {t.col, t.row};
            pos = sorted.size();
            while (pos > 0 && {sorted[pos-1].col, sorted[pos-1].row} > tkey) pos--;
            sorted.insert(pos, t);
          end
          cnt = sorted.size();
          for (j = 0; j < cnt; j++)
            expected_beats.push_back(make_beat(sorted[j].col, sorted[j].row,
                                               sorted[j].value, 0, 1, j == cnt - 1,
                                               StatusOk));
        end
      end
      default: expected_beats.push_back(make_beat(0, 0, 0, 0, 0, 1, StatusOk));
    endcase
  endtask

  task automatic compare_beat();
    beat_t e;
    if (expected_beats.size() == 0) begin
      $error("unexpected output beat row=%0h col=%0h", out_row_o, out_col_o);
      fail_count++;
      return;
    end
    e = expected_beats.pop_front();
    if (out_row_o !== e.row) begin
      $error("out_row: expected %0h actual %0h", e.row, out_row_o); fail_count++;
    end
    if (out_col_o !== e.col) begin
      $error("out_col: expected %0h actual %0h", e.col, out_col_o); fail_count++;
    end
    if (out_value_o !== e.value) begin
      $error("out_value: expected %0h actual %0h", e.value, out_value_o); fail_count++;
    end
    if (found_o !== e.found) begin
      $error("found: expected %0b actual %0b", e.found, found_o); fail_count++;
    end
    if (item_valid_o !== e.item_valid) begin
      $error("item_valid: expected %0b actual %0b", e.item_valid, item_valid_o);
      fail_count++;
    end
    if (last_o !== e.last) begin
      $error("last: expected %0b actual %0b", e.last, last_o); fail_count++;
    end
    if (status_o !== e.status) begin
      $error("status: expected %0d actual %0d", e.status, status_o); fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_num    = 0;
      rows_in_use = SizeReset;
      cols_in_use = SizeReset;
      fail_count  = 0;
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegRowCount) rows_in_use = pwdata[12:0];
        else cols_in_use = pwdata[12:0];
      end
      if (out_valid_o && !out_stall_i) compare_beat();
      if (in_valid_i && !in_stall_o)
        predict_command(cmd_e'(cmd_i), row_index_i, col_index_i, term_value_i);
    end
    pending_count = expected_beats.size();
  end
endmodule

[bench/testbench.sv]
// Top of the sparse matrix term store testbench: stimulus, register writes and verdict.
module testbench;
  import smts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk_i, rst_ni;
  logic                 psel, penable, pwrite, pready;
  logic [PaddrBits-1:0] paddr;
  logic [PdataBits-1:0] pwdata, prdata;
  logic                 in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [1:0]           cmd_i, status_o;
  logic [11:0]          row_index_i, col_index_i, out_row_o, out_col_o;
  logic [31:0]          term_value_i, out_value_o;
  logic                 found_o, item_valid_o, last_o;
  int                   fail_count, pending_count;
  int                   send_idle_pct, recv_stall_pct;
  bit                   hold_off;
  longint               cycle_count;

  sparse_matrix_term_store uut (.*);
  sparse_matrix_term_store_checker checker_inst (.*);

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 8_000_000) begin
      $display("sparse_matrix_term_store regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) out_stall_i <= hold_off;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_register(reg_e idx, logic [12:0] value);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= PdataBits'(value);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_command(cmd_e cmd, logic [11:0] r, logic [11:0] c, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; cmd_i <= cmd; row_index_i <= r; col_index_i <= c; term_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20000) @(posedge clk_i);
  endtask

  task automatic random_phase(int count, logic [11:0] span);
    int k;
    cmd_e cmd;
    logic [31:0] v;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: cmd = CmdSet;
        5, 6, 7: cmd = CmdGet;
        8: cmd = ($urandom_range(3) == 0) ? CmdNone : CmdTranspose;
        default: cmd = CmdGet;
      endcase
      v = $urandom();
      if ($urandom_range(15) == 0) v = {v[31], 31'd0};
      if ($urandom_range(7) == 0)
        send_command(cmd, 12'($urandom()), 12'($urandom()), v);
      else
        send_command(cmd, 12'($urandom_range(span)), 12'($urandom_range(span)), v);
    end
  endtask

  initial begin
    int k;
    cycle_count = 0; hold_off = 0; send_idle_pct = 0; recv_stall_pct = 0;
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; out_stall_i = 0; cmd_i = 0; row_index_i = 0; col_index_i = 0;
    term_value_i = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_command(CmdTranspose, 0, 0, 0);
    send_command(CmdSet, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
    send_command(CmdSet, 0, 0, 32'h8000_0000);
    send_command(CmdSet, 0, 0, 32'h0000_0000);
    send_command(CmdSet, 0, 0, 32'h0000_0001);
    send_command(CmdSet, 0, 12'hFFF, 32'h3F80_0000);
    send_command(CmdSet, 12'hFFF, 0, 32'h8000_0001);
    send_command(CmdSet, 0, 0, 32'h4000_0000);
    send_command(CmdGet, 0, 0, 0);
    send_command(CmdGet, 5, 5, 32'hFFFF_FFFF);
    send_command(CmdGet, 12'hFFF, 12'hFFF, 0);
    send_command(CmdNone, 12'hABC, 12'h543, 32'h1234_5678);
    send_command(CmdTranspose, 0, 0, 0);
    drain();

    write_register(RegRowCount, 13'd4);
    write_register(RegColumnCount, 13'd1);
    send_command(CmdSet, 4, 0, 32'h1);
    send_command(CmdSet, 0, 1, 32'h1);
    send_command(CmdSet, 9, 9, 32'h0);
    send_command(CmdGet, 12'hFFF, 0, 0);
    send_command(CmdSet, 3, 0, 32'h5);
    send_command(CmdTranspose, 0, 0, 0);
    drain();
    write_register(RegRowCount, 13'd0);
    write_register(RegColumnCount, 13'd8191);
    send_command(CmdGet, 0, 0, 0);
    send_command(CmdSet, 0, 7, 32'h7);
    drain();
    write_register(RegRowCount, 13'd4096);
    write_register(RegColumnCount, 13'd4096);

    for (k = 0; k < 64; k++)
      send_command(CmdSet, 12'(k % 8), 12'(k / 8), $urandom() | 32'h1);
    send_command(CmdTranspose, 0, 0, 0);
    drain();

    send_idle_pct = 75;
    random_phase(10, 12'd15);
    drain();
    send_idle_pct = 0; recv_stall_pct = 75;
    random_phase(10, 12'd15);
    drain();
    send_idle_pct = 24; recv_stall_pct = 24;
    write_register(RegRowCount, 13'd12);
    write_register(RegColumnCount, 13'd4097);
    random_phase(10, 12'd15);
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;
    write_register(RegRowCount, 13'd1);
    write_register(RegColumnCount, 13'd4095);
    random_phase(8, 12'd15);
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk_i);
        hold_off = 0;
      end
      random_phase(5, 12'd15);
    join
    send_command(CmdTranspose, 0, 0, 0);
    drain();

    if (fail_count == 0) $display("sparse_matrix_term_store regression: pass");
    else $display("sparse_matrix_term_store regression: fail");
    $finish;
  end
endmodule
